/* design/hashed_timing_wheel_unit_macros.svh */
// assertion macros for the timing wheel unit
`ifndef HASHED_TIMING_WHEEL_UNIT_MACROS_SVH
`define HASHED_TIMING_WHEEL_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define HTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htw check failed");

// implication whose consequent is checked in the next cycle
`define HTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htw check failed");

`endif

/* design/htw_pkg.sv */
// ---------------------------------------------------------------------------
// htw_pkg
// types and constants of the hashed timing wheel
// ---------------------------------------------------------------------------
package htw_pkg;

  localparam int SLOTS       = 64;
  localparam int ENTRIES     = 64;
  localparam int MAX_RESULTS = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ENT_W       = $clog2(ENTRIES);
  localparam int ROUNDS_W    = 16 - SLOT_W;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic       OP_ADD      = 1'b0;
  localparam logic       OP_TICK     = 1'b1;
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_ADD_LINK,
    ST_ADD_OUT,
    ST_TICK_HEAD,
    ST_TICK_READ,
    ST_TICK_EVAL,
    ST_TICK_OUT,
    ST_TICK_DONE
  } state_t;

endpackage

/* design/htw_free_search.sv */
// ---------------------------------------------------------------------------
// htw_free_search
// finds the lowest free pool entry, 8 busy bits a cycle
// ---------------------------------------------------------------------------
module htw_free_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [htw_pkg::ENTRIES-1:0] busy,
  output logic                        done,
  output logic                        found,
  output logic [htw_pkg::ENT_W-1:0]   idx
);

  localparam int GRP = 8;
  localparam int NGRP = (htw_pkg::ENTRIES + GRP - 1) / GRP;
  localparam int GW = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic          run_r, run_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic          hit;
  logic [htw_pkg::ENT_W-1:0] hit_idx;

  always_comb begin
    int base;
    base = int'(grp_r) * GRP;
    hit = 1'b0;
    hit_idx = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (base + i < htw_pkg::ENTRIES) begin
        if (!busy[base + i]) begin
          hit = 1'b1;
          hit_idx = htw_pkg::ENT_W'(base + i);
        end
      end
    end
  end

  always_comb begin
    run_nxt = run_r;
    grp_nxt = grp_r;
    done = 1'b0;
    found = 1'b0;
    idx = hit_idx;
    if (start) begin
      run_nxt = 1'b1;
      grp_nxt = '0;
    end else if (run_r) begin
      if (hit || int'(grp_r) == NGRP - 1) begin
        done = 1'b1;
        found = hit;
        run_nxt = 1'b0;
      end else begin
        grp_nxt = grp_r + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      grp_r <= '0;
    end else begin
      run_r <= run_nxt;
      grp_r <= grp_nxt;
    end
  end

endmodule

/* design/hashed_timing_wheel_unit.sv */
// ---------------------------------------------------------------------------
// hashed_timing_wheel_unit
// hashed timing wheel with a linked entry pool
// ---------------------------------------------------------------------------
// in_ beats carry op, delay_ticks and timer_tag; op add files a timer in slot
// (current + delay) mod 64 with delay / 64 rounds, op tick walks the current
// slot's list. out_ beats carry kind, expired_tag and last.
// an add gives one beat: accepted or rejected when all 64 entries are busy.
// a tick gives one beat per expired timer, in list order, last on the final
// one, and none when nothing expires; the slot then advances.
// one item at a time: in_stall is high from acceptance until the last beat
// has been taken. an add waits on the free entry search, which scans 8
// busy bits a cycle; a tick walks the slot's list one entry at a time
// through the entry memories.
// a held out_stall freezes the result register and the walk behind it.
// reset clears the current slot, slot valid bits and entry busy bits; list
// memories need no clearing.
// ---------------------------------------------------------------------------
module hashed_timing_wheel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_delay_ticks,
  input  logic [15:0] in_timer_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_expired_tag,
  output logic        out_last
);

  `include "hashed_timing_wheel_unit_macros.svh"

  localparam int SW = htw_pkg::SLOT_W;
  localparam int EW = htw_pkg::ENT_W;
  localparam int RW = htw_pkg::ROUNDS_W;
  localparam int CW = htw_pkg::CNT_W;

  htw_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] cur_slot_r, cur_slot_nxt;
  logic [htw_pkg::SLOTS-1:0] slot_ne_r, slot_ne_nxt;
  logic [htw_pkg::ENTRIES-1:0] busy_r, busy_nxt;

  // memories
  logic [EW-1:0] slot_head_m [htw_pkg::SLOTS];
  logic [EW-1:0] slot_tail_m [htw_pkg::SLOTS];
  logic [EW-1:0] ent_next_m [htw_pkg::ENTRIES];
  logic [RW-1:0] ent_rounds_m [htw_pkg::ENTRIES];
  logic [15:0]   ent_tag_m [htw_pkg::ENTRIES];

  logic [EW-1:0] head_rd_r, tail_rd_r, next_rd_r;
  logic [RW-1:0] rounds_rd_r;
  logic [15:0]   tag_rd_r;

  // item registers
  logic [15:0]   delay_r, tag_r;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] prev_r, prev_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [EW-1:0] head_r, head_nxt;
  logic [EW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          fin_r, fin_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [15:0]   pend_tag_r, pend_tag_nxt;

  // output register
  logic          ov_r, ov_nxt;
  logic [1:0]    ok_r, ok_nxt;
  logic [15:0]   ot_r, ot_nxt;
  logic          ol_r, ol_nxt;

  // memory write controls
  logic          hd_we, tl_we, nx_we, rd_we, tg_we;
  logic [SW-1:0] hd_wa, tl_wa;
  logic [EW-1:0] hd_wd, tl_wd, nx_wa, nx_wd, rd_wa, tg_wa;
  logic [RW-1:0] rd_wd;
  logic [SW-1:0] srd_a;
  logic [EW-1:0] erd_a;

  logic fs_start, fs_done, fs_found;
  logic [EW-1:0] fs_idx;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;
  assign in_stall = (state_r != htw_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_expired_tag = ot_r;
  assign out_last = ol_r;

  htw_free_search u_fs (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fs_start),
    .busy  (busy_r),
    .done  (fs_done),
    .found (fs_found),
    .idx   (fs_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htw_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_op == htw_pkg::OP_ADD) ? htw_pkg::ST_FIND : htw_pkg::ST_TICK_HEAD;
        end
      end
      htw_pkg::ST_FIND: begin
        if (fs_done && !ov_r) begin
          state_nxt = fs_found ? htw_pkg::ST_ADD_LINK : htw_pkg::ST_ADD_OUT;
        end
      end
      htw_pkg::ST_ADD_LINK: state_nxt = htw_pkg::ST_ADD_OUT;
      htw_pkg::ST_ADD_OUT: begin
        if (out_acc) state_nxt = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_TICK_HEAD: begin
        state_nxt = slot_ne_r[cur_slot_r] ? htw_pkg::ST_TICK_READ : htw_pkg::ST_TICK_DONE;
      end
      htw_pkg::ST_TICK_READ: state_nxt = htw_pkg::ST_TICK_EVAL;
      htw_pkg::ST_TICK_EVAL: begin
        if (!ov_r || out_acc) state_nxt = htw_pkg::ST_TICK_OUT;
      end
      htw_pkg::ST_TICK_OUT: begin
        state_nxt = fin_r ? htw_pkg::ST_TICK_DONE : htw_pkg::ST_TICK_READ;
      end
      htw_pkg::ST_TICK_DONE: begin
        // a held expiry still goes out as the last beat
        if (!ov_r || out_acc) state_nxt = pend_v_r ? htw_pkg::ST_ADD_OUT : htw_pkg::ST_IDLE;
      end
      default: state_nxt = htw_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic is_tail, expire;
    logic [15:0] sum;
    is_tail = (cur_r == tail_r);
    expire = (rounds_rd_r == '0) && (int'(cnt_r) < htw_pkg::MAX_RESULTS);
    sum = 16'(cur_slot_r) + delay_r;

    cur_slot_nxt = cur_slot_r;
    slot_ne_nxt = slot_ne_r;
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    ent_nxt = ent_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    have_prev_nxt = have_prev_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    pend_v_nxt = pend_v_r;
    pend_tag_nxt = pend_tag_r;
    ov_nxt = ov_r && out_stall;
    ok_nxt = ok_r;
    ot_nxt = ot_r;
    ol_nxt = ol_r;
    fs_start = 1'b0;
    hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; rd_we = 1'b0; tg_we = 1'b0;
    hd_wa = slot_r; tl_wa = slot_r; hd_wd = ent_r; tl_wd = ent_r;
    nx_wa = ent_r; nx_wd = '0; rd_wa = ent_r; rd_wd = '0; tg_wa = ent_r;
    srd_a = slot_r;
    erd_a = cur_r;

    unique case (state_r)
      htw_pkg::ST_IDLE: begin
        fs_start = in_acc && (in_op == htw_pkg::OP_ADD);
        slot_nxt = cur_slot_r;
        srd_a = cur_slot_r;
      end
      htw_pkg::ST_FIND: begin
        slot_nxt = sum[SW-1:0];
        srd_a = sum[SW-1:0];
        ent_nxt = fs_idx;
        if (fs_done && !ov_r && !fs_found) begin
          ov_nxt = 1'b1; ok_nxt = htw_pkg::KIND_REJECT; ot_nxt = tag_r; ol_nxt = 1'b1;
        end
      end
      htw_pkg::ST_ADD_LINK: begin
        busy_nxt[ent_r] = 1'b1;
        rd_we = 1'b1; rd_wd = delay_r[15:SW];
        tg_we = 1'b1;
        tl_we = 1'b1;
        if (slot_ne_r[slot_r]) begin
          nx_we = 1'b1; nx_wa = tail_rd_r; nx_wd = ent_r;
        end else begin
          hd_we = 1'b1;
          slot_ne_nxt[slot_r] = 1'b1;
        end
        ov_nxt = 1'b1; ok_nxt = htw_pkg::KIND_ACCEPT; ot_nxt = tag_r; ol_nxt = 1'b1;
      end
      htw_pkg::ST_ADD_OUT: ;
      htw_pkg::ST_TICK_HEAD: begin
        cur_nxt = head_rd_r;
        head_nxt = head_rd_r;
        tail_nxt = tail_rd_r;
        have_prev_nxt = 1'b0;
        cnt_nxt = '0;
        pend_v_nxt = 1'b0;
        erd_a = head_rd_r;
      end
      htw_pkg::ST_TICK_READ: ;
      htw_pkg::ST_TICK_EVAL: begin
        if (!ov_r || out_acc) begin
          fin_nxt = is_tail;
          if (expire) begin
            if (have_prev_r) begin
              nx_we = 1'b1; nx_wa = prev_r; nx_wd = next_rd_r;
            end else begin
              head_nxt = next_rd_r;
            end
            if (is_tail) begin
              if (have_prev_r) tail_nxt = prev_r;
              else slot_ne_nxt[slot_r] = 1'b0;
            end
            busy_nxt[cur_r] = 1'b0;
            cnt_nxt = cnt_r + CW'(1);
            // a newer expiry means the held one is not the last
            if (pend_v_r) begin
              ov_nxt = 1'b1; ok_nxt = htw_pkg::KIND_EXPIRE; ot_nxt = pend_tag_r;
              ol_nxt = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_tag_nxt = tag_rd_r;
          end else begin
            if (rounds_rd_r != '0) begin
              rd_we = 1'b1; rd_wa = cur_r; rd_wd = rounds_rd_r - RW'(1);
            end
            prev_nxt = cur_r;
            have_prev_nxt = 1'b1;
          end
          cur_nxt = next_rd_r;
        end
      end
      htw_pkg::ST_TICK_OUT: begin
        erd_a = cur_r;
      end
      htw_pkg::ST_TICK_DONE: begin
        // release the held expiry as the last beat
        if (!ov_r || out_acc) begin
          hd_we = 1'b1; hd_wd = head_r;
          tl_we = 1'b1; tl_wd = tail_r;
          cur_slot_nxt = cur_slot_r + SW'(1);
          if (pend_v_r) begin
            ov_nxt = 1'b1; ok_nxt = htw_pkg::KIND_EXPIRE; ot_nxt = pend_tag_r;
            ol_nxt = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htw_pkg::ST_IDLE;
      cur_slot_r <= '0;
      slot_ne_r <= '0;
      busy_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_slot_r <= cur_slot_nxt;
      slot_ne_r <= slot_ne_nxt;
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers; an expiry beat is held back until the next expiry or the end of the walk so last is known
  always_ff @(posedge clk) begin
    if (in_acc) begin
      delay_r <= in_delay_ticks;
      tag_r <= in_timer_tag;
    end
    slot_r <= slot_nxt;
    ent_r <= ent_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    cnt_r <= cnt_nxt;
    fin_r <= fin_nxt;
    pend_v_r <= pend_v_nxt;
    pend_tag_r <= pend_tag_nxt;
    ok_r <= ok_nxt;
    ot_r <= ot_nxt;
    ol_r <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (hd_we) slot_head_m[hd_wa] <= hd_wd;
    if (tl_we) slot_tail_m[tl_wa] <= tl_wd;
    head_rd_r <= slot_head_m[srd_a];
    tail_rd_r <= slot_tail_m[srd_a];
  end

  always_ff @(posedge clk) begin
    if (nx_we) ent_next_m[nx_wa] <= nx_wd;
    if (rd_we) ent_rounds_m[rd_wa] <= rd_wd;
    if (tg_we) ent_tag_m[tg_wa] <= tag_r;
    next_rd_r <= ent_next_m[erd_a];
    rounds_rd_r <= ent_rounds_m[erd_a];
    tag_rd_r <= ent_tag_m[erd_a];
  end

  `HTW_ASSERT_IMPL(a_busy_when_out, out_valid, in_stall)
  `HTW_ASSERT_IMPL(a_add_last, out_valid && out_kind != htw_pkg::KIND_EXPIRE, out_last)
  `HTW_ASSERT_NEXT(a_tick_advance, state_r == htw_pkg::ST_TICK_DONE && !(ov_r && out_stall),
                   cur_slot_r == $past(cur_slot_r) + SW'(1))
  `HTW_ASSERT_IMPL(a_idle_drained, state_r == htw_pkg::ST_IDLE, !ov_r)

endmodule
